### design/positional_list_engine_defines.svh
// Assertion macros for the positional list engine.
// All of them sample on i_clk and are disabled while i_rst_n is low.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define PLE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional list engine: same-cycle check failed");

// Next-cycle implication.
`define PLE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional list engine: next-cycle check failed");

`endif

### design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, operation codes and the cell control struct of the
// positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPLACE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRAVERSE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // Broadcast to every cell; each cell compares pos with its own index.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rep;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

### design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot. Above the target position it takes the left neighbor on insert;
// at or above it, the right neighbor on delete; at it, the broadcast value on insert or replace.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  wire                    i_clk,
    input  wire ple_pkg::t_cell_ctl i_ctl,
    input  wire [DATA_WIDTH-1:0]   i_value,
    input  wire [DATA_WIDTH-1:0]   i_left,
    input  wire [DATA_WIDTH-1:0]   i_right,
    output logic [DATA_WIDTH-1:0]  o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_above;
    logic                  w_here;

    assign w_above = IDX > int'(i_ctl.pos);
    assign w_here  = IDX == int'(i_ctl.pos);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && w_above) begin
            n_data = i_left;
        end else if ((i_ctl.ins || i_ctl.rep) && w_here) begin
            n_data = i_value;
        end else if (i_ctl.del && (w_above || w_here)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### design/positional_list_engine.sv
// A result is in the output register in the cycle after its request.
// Throughput: one request per cycle while the output takes every result; traverse
// holds the input off, also through any output stall, until every entry is emitted,
// as the read mux steps one cell per emitted result through the chain.
// Reset (synchronous, i_rst_n low) empties the list, returns to idle and drops
// any pending result; cell contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list held in a chain of cells with positional insert, delete, read,
// replace, traverse and clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_list_engine_defines.svh"

module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,   // position[3:0], value[35:4], zero fill
    input  wire  [2:0]  i_s_axis_tuser,   // mode[2:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // status[1:0], read_value[33:2],
                                          // item_valid[34], entry_count[39:35],
                                          // is_empty[40], zero fill
    output logic        o_m_axis_tlast    // last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TRAV = 1'b1;

    logic                                r_state, n_state;
    logic [PW-1:0]                       r_idx, n_idx;
    logic [CW-1:0]                       r_count, n_count;
    logic                                r_ov, n_ov;
    logic [ple_pkg::STATUS_W-1:0]        r_status, n_status;
    logic [ple_pkg::VALUE_W-1:0]         r_rdata, n_rdata;
    logic                                r_ivalid, n_ivalid;
    logic [CW-1:0]                       r_ocnt, n_ocnt;
    logic                                r_last, n_last;

    logic                                w_acc;
    logic                                w_slot;
    logic [ple_pkg::MODE_W-1:0]          w_mode;
    logic [ple_pkg::POS_W-1:0]           w_pos;
    logic [DATA_WIDTH-1:0]               w_value;
    logic                                w_pos_ge;
    logic                                w_pos_gt;
    logic [PW-1:0]                       w_rd_idx;
    logic [DATA_WIDTH-1:0]               w_rd;
    logic [ple_pkg::VALUE_W-1:0]         w_rd32;
    logic [ple_pkg::VALUE_W-1:0]         w_first32;
    ple_pkg::t_cell_ctl                  w_ctl;
    logic [DATA_WIDTH-1:0]               w_cell [DEPTH];

    assign w_mode  = i_s_axis_tuser;
    assign w_pos   = i_s_axis_tdata[3:0];
    assign w_value = DATA_WIDTH'(64'(i_s_axis_tdata[35:4]));

    assign w_slot          = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_slot;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign w_pos_ge = int'(w_pos) >= int'(r_count);
    assign w_pos_gt = int'(w_pos) > int'(r_count);

    assign w_rd_idx  = (r_state == ST_TRAV) ? r_idx : PW'(w_pos);
    assign w_rd      = w_cell[w_rd_idx];
    assign w_rd32    = ple_pkg::VALUE_W'(64'(w_rd));
    assign w_first32 = ple_pkg::VALUE_W'(64'(w_cell[0]));

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_lo
                assign w_left = w_value;
            end else begin : g_lo
                assign w_left = w_cell[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_hi
                assign w_right = w_cell[gi];
            end else begin : g_hi
                assign w_right = w_cell[gi+1];
            end
            ple_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_value (w_value),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_cell[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_ov     = r_ov && !i_m_axis_tready;
        n_status = r_status;
        n_rdata  = r_rdata;
        n_ivalid = r_ivalid;
        n_ocnt   = r_ocnt;
        n_last   = r_last;
        w_ctl    = '0;
        w_ctl.pos = w_pos;

        if (w_acc) begin
            n_ov     = 1'b1;
            n_status = ple_pkg::STATUS_OK;
            n_rdata  = '0;
            n_ivalid = 1'b0;
            n_last   = 1'b1;
            case (w_mode)
                ple_pkg::MODE_INSERT: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ple_pkg::STATUS_FULL;
                    end else if (w_pos_gt) begin
                        n_status = ple_pkg::STATUS_RANGE;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = CW'(r_count + 1'b1);
                    end
                end
                ple_pkg::MODE_DELETE: begin
                    if (w_pos_ge) begin
                        n_status = ple_pkg::STATUS_RANGE;
                    end else begin
                        w_ctl.del = 1'b1;
                        n_rdata   = w_rd32;
                        n_ivalid  = 1'b1;
                        n_count   = CW'(r_count - 1'b1);
                    end
                end
                ple_pkg::MODE_READ: begin
                    if (w_pos_ge) begin
                        n_status = ple_pkg::STATUS_RANGE;
                    end else begin
                        n_rdata  = w_rd32;
                        n_ivalid = 1'b1;
                    end
                end
                ple_pkg::MODE_REPLACE: begin
                    if (w_pos_ge) begin
                        n_status = ple_pkg::STATUS_RANGE;
                    end else begin
                        w_ctl.rep = 1'b1;
                    end
                end
                ple_pkg::MODE_TRAVERSE: begin
                    if (r_count != '0) begin
                        n_rdata  = w_first32;
                        n_ivalid = 1'b1;
                        n_last   = (r_count == CW'(1));
                        if (r_count != CW'(1)) begin
                            n_state = ST_TRAV;
                            n_idx   = PW'(1);
                        end
                    end
                end
                ple_pkg::MODE_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
            n_ocnt = n_count;
        end else if ((r_state == ST_TRAV) && w_slot) begin
            // emit the next entry; leave traverse after the one below count
            n_ov     = 1'b1;
            n_status = ple_pkg::STATUS_OK;
            n_rdata  = w_rd32;
            n_ivalid = 1'b1;
            n_ocnt   = r_count;
            n_last   = (int'(r_idx) + 1 == int'(r_count));
            if (n_last) begin
                n_state = ST_IDLE;
            end else begin
                n_idx = PW'(r_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rdata  <= n_rdata;
        r_ivalid <= n_ivalid;
        r_ocnt   <= n_ocnt;
        r_last   <= n_last;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tdata  = {7'd0, (r_ocnt == '0), ple_pkg::CNT_W'(r_ocnt),
                              r_ivalid, r_rdata, r_status};

    `PLE_ASSERT_IMP(a_count_bound, 1'b1, int'(r_count) <= DEPTH)
    `PLE_ASSERT_NXT(a_insert_grows,
        w_acc && (w_mode == ple_pkg::MODE_INSERT) && (r_count != CW'(DEPTH)) && !w_pos_gt,
        r_count == CW'($past(r_count) + 1'b1))
    `PLE_ASSERT_IMP(a_noitem_final, r_ov && !r_ivalid, r_last)

endmodule

`default_nettype wire
